FILE: rtl/nfa_em_pkg.sv
// ----------------------------------------------------------------------------
// nfa_em_pkg
// Shared types, widths and codes for the epsilon-NFA matcher.
// ----------------------------------------------------------------------------
package nfa_em_pkg;

  localparam int unsigned NumStates = 16;
  localparam int unsigned AlphaSize = 256;
  localparam int unsigned StateW    = 4;
  localparam int unsigned SymW      = 8;
  localparam int unsigned CntW      = 5;
  localparam int unsigned SetW      = NumStates;
  localparam int unsigned RowW      = NumStates * SetW;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  typedef logic [SetW-1:0]   set_t;
  typedef logic [StateW-1:0] state_t;
  typedef logic [SymW-1:0]   sym_t;
  typedef logic [RowW-1:0]   row_t;
  typedef logic [CntW-1:0]   cnt_t;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_BEGIN   = 2'd1,
    REQ_CONSUME = 2'd2
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_STATE = 2'd0,
    CFG_ACCEPT_MASK = 2'd1,
    CFG_STATE_COUNT = 2'd2
  } cfg_idx_e;

  // states below the effective count, count saturating at NumStates
  function automatic set_t count_mask(cnt_t n);
    set_t m;
    m = '0;
    for (int i = 0; i < NumStates; i++) begin
      m[i] = (int'(n) > i);
    end
    return m;
  endfunction

endpackage

FILE: rtl/nfa_em_if.sv
// ----------------------------------------------------------------------------
// nfa_em_if
// Request and response channels of the epsilon-NFA matcher.
// ----------------------------------------------------------------------------
interface nfa_em_req_if;
  import nfa_em_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  sym_t       symbol;
  state_t     from_state;
  state_t     to_state;
  logic       is_epsilon;

  modport source (
    output valid, req_type, symbol, from_state, to_state, is_epsilon,
    input  ready
  );
  modport sink (
    input  valid, req_type, symbol, from_state, to_state, is_epsilon,
    output ready
  );
endinterface

interface nfa_em_rsp_if;
  import nfa_em_pkg::*;

  logic valid;
  logic ready;
  logic accepted;
  logic rule_ok;
  set_t active_set;

  modport source (
    output valid, accepted, rule_ok, active_set,
    input  ready
  );
  modport sink (
    input  valid, accepted, rule_ok, active_set,
    output ready
  );
endinterface

FILE: rtl/nfa_epsilon_matcher.sv
// ----------------------------------------------------------------------------
// nfa_epsilon_matcher
// Epsilon-NFA matcher: loads transition rules, begins matches and consumes
// symbols, returning acceptance and the active state set for every request.
// ----------------------------------------------------------------------------
// One request is processed at a time and each gives exactly one response
// transaction. A symbol rule passes the read and done states, an epsilon
// rule, rejected rule or unused request only the done state. A begin runs
// the epsilon closure, a consume the read state then the closure, both
// ending in the done state. The closure makes 1 to 16 passes, one pass per
// cycle over the epsilon table, until the set stops growing. The symbol
// transitions live in a 256-row memory, one row per symbol holding the
// successor sets of all states, read into a register once per request.
// Per-row valid bits clear the memory at reset, so there is no clearing
// pass. A new request is taken while the previous response still waits.
module nfa_epsilon_matcher (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  nfa_em_req_if.sink                     req_i,
  nfa_em_rsp_if.source                   rsp_o,
  input  logic                           cfg_we_i,
  input  logic [nfa_em_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [nfa_em_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import nfa_em_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CLOS = 4'b0100,
    S_DONE = 4'b1000
  } fsm_e;

  fsm_e       state_q, state_d;
  state_t     start_q;
  set_t       amask_q;
  cnt_t       count_q;
  set_t       eps_q [NumStates];
  logic       row_vld_q [AlphaSize];
  row_t       sym_mem [AlphaSize];
  row_t       rd_q;
  logic [1:0] req_q;
  sym_t       sym_q;
  state_t     from_q;
  state_t     to_q;
  logic       ok_q;
  set_t       cur_q;
  set_t       act_q;
  logic       rsp_vld_q;
  logic       rsp_acc_q;
  logic       rsp_ok_q;
  set_t       rsp_set_q;

  logic in_acc;
  logic out_free;
  logic range_ok;
  logic start_ok;
  logic sym_rule;
  logic row_wr;
  logic set_upd;
  set_t cmask;
  set_t eps_union;
  set_t clos_nxt;
  set_t sym_union;
  set_t to_bit;
  set_t res_set;
  row_t row_live;
  row_t row_new;

  assign req_i.ready = (state_q == S_IDLE);
  assign in_acc      = req_i.valid && (state_q == S_IDLE);
  assign out_free    = !rsp_vld_q || rsp_o.ready;

  assign cmask    = count_mask(count_q);
  assign range_ok = ({1'b0, req_i.from_state} < count_q) &&
                    ({1'b0, req_i.to_state} < count_q);
  assign start_ok = ({1'b0, start_q} < count_q);
  assign sym_rule = (req_i.req_type == REQ_LOAD) && range_ok && !req_i.is_epsilon;
  assign row_wr   = (state_q == S_READ) && (req_q == REQ_LOAD);
  assign set_upd  = (req_q == REQ_BEGIN) || (req_q == REQ_CONSUME);
  assign res_set  = set_upd ? cur_q : act_q;
  assign row_live = row_vld_q[sym_q] ? rd_q : '0;
  assign to_bit   = set_t'(1) << to_q;

  // one epsilon pass over the current set
  always_comb begin
    eps_union = '0;
    for (int s = 0; s < NumStates; s++) begin
      if (cur_q[s]) begin
        eps_union = eps_union | eps_q[s];
      end
    end
    clos_nxt = (cur_q | eps_union) & cmask;
  end

  // symbol successors of the active set from the row just read
  always_comb begin
    sym_union = '0;
    for (int s = 0; s < NumStates; s++) begin
      if (act_q[s]) begin
        sym_union = sym_union | row_live[s*SetW +: SetW];
      end
    end
  end

  always_comb begin
    for (int s = 0; s < NumStates; s++) begin
      row_new[s*SetW +: SetW] = row_live[s*SetW +: SetW] |
                                ((state_t'(s) == from_q) ? to_bit : '0);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (req_i.req_type)
            REQ_LOAD:    state_d = sym_rule ? S_READ : S_DONE;
            REQ_BEGIN:   state_d = S_CLOS;
            REQ_CONSUME: state_d = S_READ;
            default:     state_d = S_DONE;
          endcase
        end
      end
      S_READ: begin
        state_d = (req_q == REQ_LOAD) ? S_DONE : S_CLOS;
      end
      S_CLOS: begin
        if (clos_nxt == cur_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      start_q   <= '0;
      amask_q   <= '0;
      count_q   <= cnt_t'(1);
      act_q     <= '0;
      rsp_vld_q <= 1'b0;
      for (int s = 0; s < NumStates; s++) begin
        eps_q[s] <= '0;
      end
      for (int r = 0; r < AlphaSize; r++) begin
        row_vld_q[r] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_START_STATE: start_q <= cfg_wdata_i[StateW-1:0];
          CFG_ACCEPT_MASK: amask_q <= cfg_wdata_i[SetW-1:0];
          CFG_STATE_COUNT: begin
            if (cfg_wdata_i[CntW-1:0] != '0) begin
              count_q <= cfg_wdata_i[CntW-1:0];
            end
          end
          default: ;
        endcase
      end
      if (in_acc && (req_i.req_type == REQ_LOAD) && range_ok && req_i.is_epsilon) begin
        eps_q[req_i.from_state] <= eps_q[req_i.from_state] |
                                   (set_t'(1) << req_i.to_state);
      end
      if (row_wr) begin
        row_vld_q[sym_q] <= 1'b1;
      end
      if ((state_q == S_DONE) && out_free) begin
        rsp_vld_q <= 1'b1;
        if (set_upd) begin
          act_q <= cur_q;
        end
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q  <= req_i.req_type;
      sym_q  <= req_i.symbol;
      from_q <= req_i.from_state;
      to_q   <= req_i.to_state;
      ok_q   <= !((req_i.req_type == REQ_LOAD) && !range_ok);
      cur_q  <= start_ok ? ((set_t'(1) << start_q) & cmask) : '0;
    end else if ((state_q == S_READ) && (req_q == REQ_CONSUME)) begin
      cur_q <= sym_union & cmask;
    end else if (state_q == S_CLOS) begin
      cur_q <= clos_nxt;
    end
    if ((state_q == S_DONE) && out_free) begin
      rsp_acc_q <= |(res_set & amask_q);
      rsp_ok_q  <= ok_q;
      rsp_set_q <= res_set;
    end
  end

  // symbol transition memory, one row per symbol
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= sym_mem[req_i.symbol];
    end
    if (row_wr) begin
      sym_mem[sym_q] <= row_new;
    end
  end

  assign rsp_o.valid      = rsp_vld_q;
  assign rsp_o.accepted   = rsp_acc_q;
  assign rsp_o.rule_ok    = rsp_ok_q;
  assign rsp_o.active_set = rsp_set_q;

  a_accept_leaves_idle: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != S_IDLE)
  ) else $error("request accepted but controller stayed idle");

  a_clos_within_count: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLOS) |-> ((cur_q & ~cmask) == '0)
  ) else $error("closure set holds states beyond the count");

  a_rsp_from_done: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_vld_q) |-> $past(state_q == S_DONE)
  ) else $error("response raised outside the done state");

  a_row_marked: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    row_wr |=> row_vld_q[sym_q]
  ) else $error("written symbol row not marked valid");

endmodule
